FILE: hdl/mfa_pkg.sv
`default_nettype none

package mfa_pkg;

   localparam int PRIME_BITS_DEF = 61;
   localparam int OPERAND_W      = 64;
   localparam int RESULT_W       = 61;
   localparam int FUNC_W         = 3;
   localparam int DIGIT_W        = 4;

   // function codes
   localparam logic [FUNC_W-1:0] FUNC_REDUCE = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_SUB    = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_MUL    = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_DIV    = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_POW    = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED_A,
      ST_RED_B,
      ST_EXEC,
      ST_POW_SQ,
      ST_POW_SQ_W,
      ST_POW_MUL,
      ST_POW_MUL_W,
      ST_POW_NEXT,
      ST_MUL_W,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

FILE: hdl/mfa_modmul.sv
`default_nettype none

module mfa_modmul
   import mfa_pkg::*;
#(
   parameter int PRIME_BITS = PRIME_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [PRIME_BITS-1:0] op_x,
   input  wire logic [PRIME_BITS-1:0] op_y,
   output logic                       done,
   output logic [PRIME_BITS-1:0]      product
);

   localparam int NDIG  = (PRIME_BITS + DIGIT_W - 1) / DIGIT_W;
   localparam int YW    = NDIG * DIGIT_W;
   localparam int CNT_W = $clog2(NDIG + 1);
   localparam logic [PRIME_BITS:0] FIELD_P1 = {1'b0, {PRIME_BITS{1'b1}}};

   logic                    busy_ff;
   logic                    done_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic [PRIME_BITS-1:0]   x_ff;
   logic [YW-1:0]           y_ff;
   logic [PRIME_BITS-1:0]   acc_ff;

   logic [DIGIT_W-1:0]            digit;
   logic [PRIME_BITS-1:0]         rot;
   logic [PRIME_BITS+DIGIT_W-1:0] part;
   logic [PRIME_BITS:0]           fold1;
   logic [PRIME_BITS+1:0]         total;
   logic [PRIME_BITS:0]           fold2;
   logic [PRIME_BITS:0]           step_sum;
   logic [PRIME_BITS-1:0]         acc_in;

   // one radix-16 digit of y per cycle, msb first: acc = acc*16 + x*digit mod p
   // times 16 mod a mersenne prime is a rotate
   always_comb begin
      digit    = y_ff[YW-1 -: DIGIT_W];
      rot      = {acc_ff[PRIME_BITS-DIGIT_W-1:0], acc_ff[PRIME_BITS-1:PRIME_BITS-DIGIT_W]};
      part     = (PRIME_BITS+DIGIT_W)'(x_ff) * (PRIME_BITS+DIGIT_W)'(digit);
      fold1    = (PRIME_BITS+1)'(part[PRIME_BITS-1:0])
               + (PRIME_BITS+1)'(part[PRIME_BITS+DIGIT_W-1:PRIME_BITS]);
      total    = (PRIME_BITS+2)'(rot) + (PRIME_BITS+2)'(fold1);
      fold2    = (PRIME_BITS+1)'(total[PRIME_BITS-1:0])
               + (PRIME_BITS+1)'(total[PRIME_BITS+1:PRIME_BITS]);
      step_sum = (fold2 >= FIELD_P1) ? fold2 - FIELD_P1 : fold2;
      acc_in   = step_sum[PRIME_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NDIG);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= op_x;
         y_ff   <= YW'(op_y);
         acc_ff <= '0;
      end else if (busy_ff) begin
         y_ff   <= y_ff << DIGIT_W;
         acc_ff <= acc_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

FILE: hdl/mersenne_field_alu_core.sv
`default_nettype none

// channel   | dir | transfer when            | contents
// ----------+-----+--------------------------+-----------------------------------------
// req_      | in  | req_tvalid & req_tready  | tuser: func; tdata: operand_a, operand_b
// rsp_      | out | rsp_tvalid & rsp_tready  | tuser: div_zero; tdata: field_result
//
// one item at a time: req_tready is high only while idle, the result is held on rsp_ until its
// transfer; each raw operand folds once a cycle until it is no more than p; add, subtract and
// reduce are computed in the execute state; a modular multiply runs on the shared digit-serial
// unit; exponentiate: up to 64 squarings, those of 1 skipped, plus one multiply per set
// exponent bit; divide is b^(p-2) then one multiply; reset is synchronous and drops any item
// in flight
module mersenne_field_alu_core
   import mfa_pkg::*;
#(
   parameter int PRIME_BITS = PRIME_BITS_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   // request side
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [127:0]  req_tdata,   // [63:0] operand_a, [127:64] operand_b
   input  wire logic [2:0]    req_tuser,   // [2:0] func
   // response side
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [63:0]        rsp_tdata,   // [60:0] field_result, [63:61] zero
   output logic [0:0]         rsp_tuser    // [0] div_zero
);

   localparam logic [OPERAND_W-1:0] FIELD_P64 =
      OPERAND_W'((65'd1 << PRIME_BITS) - 65'd1);
   localparam logic [PRIME_BITS-1:0] FIELD_P  = {PRIME_BITS{1'b1}};
   localparam logic [PRIME_BITS:0]   FIELD_P1 = {1'b0, {PRIME_BITS{1'b1}}};
   localparam logic [PRIME_BITS-1:0] ONE      = PRIME_BITS'(1);

   state_type state_ff, state_in;

   logic [FUNC_W-1:0]     func_ff;
   logic [OPERAND_W-1:0]  red_ff;      // raw value being folded
   logic [OPERAND_W-1:0]  braw_ff;     // raw second operand
   logic [OPERAND_W-1:0]  exp_ff;
   logic [5:0]            bit_ff;      // exponent bit under work, msb first
   logic [PRIME_BITS-1:0] a_ff;
   logic [PRIME_BITS-1:0] b_ff;
   logic [PRIME_BITS-1:0] base_ff;
   logic [PRIME_BITS-1:0] acc_ff;
   logic [PRIME_BITS-1:0] res_ff;
   logic                  dz_ff;

   logic                  req_xfer;
   logic                  red_big;
   logic [OPERAND_W-1:0]  red_fold;
   logic [PRIME_BITS-1:0] red_final;
   logic [PRIME_BITS:0]   add_sum;
   logic [PRIME_BITS:0]   add_mod;
   logic [PRIME_BITS:0]   sub_mod;

   logic                  mul_start;
   logic [PRIME_BITS-1:0] mul_x;
   logic [PRIME_BITS-1:0] mul_y;
   logic                  mul_done;
   logic [PRIME_BITS-1:0] mul_prod;

   assign req_xfer = req_tvalid && req_tready;

   // mersenne fold of the raw word: (x & p) + (x >> k) keeps x mod p
   always_comb begin
      red_big   = red_ff > FIELD_P64;
      red_fold  = (red_ff & FIELD_P64) + (red_ff >> PRIME_BITS);
      red_final = (red_ff[PRIME_BITS-1:0] == FIELD_P) ? '0 : red_ff[PRIME_BITS-1:0];
   end

   // single-step add and subtract on reduced operands
   always_comb begin
      add_sum = (PRIME_BITS+1)'(a_ff) + (PRIME_BITS+1)'(b_ff);
      add_mod = (add_sum >= FIELD_P1) ? add_sum - FIELD_P1 : add_sum;
      if (a_ff >= b_ff) begin
         sub_mod = (PRIME_BITS+1)'(a_ff) - (PRIME_BITS+1)'(b_ff);
      end else begin
         sub_mod = (PRIME_BITS+1)'(a_ff) + FIELD_P1 - (PRIME_BITS+1)'(b_ff);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) state_in = ST_RED_A;
         end
         ST_RED_A: begin
            if (!red_big) state_in = ST_RED_B;
         end
         ST_RED_B: begin
            if (!red_big) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (func_ff)
               FUNC_MUL: state_in = ST_MUL_W;
               FUNC_DIV: state_in = (b_ff == '0) ? ST_RESP : ST_POW_SQ;
               FUNC_POW: state_in = ST_POW_SQ;
               default:  state_in = ST_RESP;
            endcase
         end
         ST_POW_SQ: begin
            state_in = (acc_ff == ONE) ? ST_POW_MUL : ST_POW_SQ_W;
         end
         ST_POW_SQ_W: begin
            if (mul_done) state_in = ST_POW_MUL;
         end
         ST_POW_MUL: begin
            state_in = exp_ff[bit_ff] ? ST_POW_MUL_W : ST_POW_NEXT;
         end
         ST_POW_MUL_W: begin
            if (mul_done) state_in = ST_POW_NEXT;
         end
         ST_POW_NEXT: begin
            if (bit_ff != '0) begin
               state_in = ST_POW_SQ;
            end else if (func_ff == FUNC_DIV) begin
               state_in = ST_MUL_W;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_MUL_W: begin
            if (mul_done) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // handshake and multiplier issue
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      mul_start  = 1'b0;
      mul_x      = acc_ff;
      mul_y      = acc_ff;
      unique case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_EXEC: begin
            mul_start = (func_ff == FUNC_MUL);
            mul_x     = a_ff;
            mul_y     = b_ff;
         end
         ST_POW_SQ: mul_start = (acc_ff != ONE);
         ST_POW_MUL: begin
            mul_start = exp_ff[bit_ff];
            mul_y     = base_ff;
         end
         ST_POW_NEXT: begin
            // divide: inverse times the reduced dividend
            mul_start = (bit_ff == '0) && (func_ff == FUNC_DIV);
            mul_y     = a_ff;
         end
         ST_RESP: rsp_tvalid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               func_ff <= req_tuser;
               red_ff  <= req_tdata[63:0];
               braw_ff <= req_tdata[127:64];
            end
         end
         ST_RED_A: begin
            if (red_big) begin
               red_ff <= red_fold;
            end else begin
               a_ff   <= red_final;
               red_ff <= braw_ff;
            end
         end
         ST_RED_B: begin
            if (red_big) begin
               red_ff <= red_fold;
            end else begin
               b_ff <= red_final;
            end
         end
         ST_EXEC: begin
            res_ff <= '0;
            dz_ff  <= 1'b0;
            acc_ff <= ONE;
            bit_ff <= '1;
            case (func_ff)
               FUNC_REDUCE: res_ff <= a_ff;
               FUNC_ADD:    res_ff <= add_mod[PRIME_BITS-1:0];
               FUNC_SUB:    res_ff <= sub_mod[PRIME_BITS-1:0];
               FUNC_DIV: begin
                  dz_ff   <= (b_ff == '0);
                  base_ff <= b_ff;
                  exp_ff  <= FIELD_P64 - OPERAND_W'(2);
               end
               FUNC_POW: begin
                  base_ff <= a_ff;
                  exp_ff  <= braw_ff;
               end
               default: ;
            endcase
         end
         ST_POW_SQ_W, ST_POW_MUL_W: begin
            if (mul_done) acc_ff <= mul_prod;
         end
         ST_POW_NEXT: begin
            bit_ff <= bit_ff - 6'd1;
            res_ff <= acc_ff;
         end
         ST_MUL_W: begin
            if (mul_done) res_ff <= mul_prod;
         end
         default: ;
      endcase
   end

   mfa_modmul #(
      .PRIME_BITS (PRIME_BITS)
   ) u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_x    (mul_x),
      .op_y    (mul_y),
      .done    (mul_done),
      .product (mul_prod)
   );

   assign rsp_tdata = {3'b000, RESULT_W'(res_ff)};
   assign rsp_tuser = dz_ff;

endmodule

`default_nettype wire

FILE: tb/tb_mersenne_field_alu_core.sv
`timescale 1ns / 100ps

module tb_mersenne_field_alu_core;
   import mfa_pkg::*;

   // field of the mersenne prime at the default build width
   localparam int PRIME_BITS = PRIME_BITS_DEF;
   localparam logic [127:0] FIELD_P = (128'd1 << PRIME_BITS) - 128'd1;
   localparam logic [63:0] P64 = FIELD_P[63:0];
   localparam logic [63:0] ALL_ONES = '1;

   // code outside the defined functions, gives a zero result
   localparam logic [FUNC_W-1:0] FUNC_UNDEF_LO = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_UNDEF_HI = 3'd7;

   localparam int RANDOM_ITEMS = 1925;
   localparam int END_QUIET_CYCLES = 64;
   // worst case per item is a divide or a full exponent,
   // plus receiver stalls; taken several times over
   localparam longint CYCLE_LIMIT = 64'd20_000_000;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [63:0]       a;
      logic [63:0]       b;
      logic              hold_until_idle;
   } field_req_type;

   typedef struct packed {
      logic [63:0] tdata;
      logic [0:0]  tuser;
   } field_rsp_type;

   logic          clock;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [127:0]  req_tdata = '0;   // [63:0] operand_a, [127:64] operand_b
   logic [2:0]    req_tuser = '0;   // [2:0] func
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [63:0]   rsp_tdata;        // [60:0] field_result, [63:61] zero
   logic [0:0]    rsp_tuser;        // [0] div_zero

   field_req_type request_queue[$];
   field_rsp_type results_due[$];
   int            total_items = 0;
   int            sent_count = 0;
   int            recv_count = 0;
   int            mismatches = 0;
   longint        cycle_count = 0;

   mersenne_field_alu_core #(
      .PRIME_BITS(PRIME_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------- field math

   // mersenne folding of a wide word down to 0..p-1
   function automatic logic [63:0] fold_mod(input logic [127:0] x);
      logic [127:0] v;
      v = x;
      while (v > FIELD_P)
         v = (v & FIELD_P) + (v >> PRIME_BITS);
      if (v == FIELD_P)
         v = '0;
      return v[63:0];
   endfunction

   function automatic logic [63:0] add_mod(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (s >= P64)
         s = s - P64;
      return s;
   endfunction

   function automatic logic [63:0] sub_mod(input logic [63:0] a, input logic [63:0] b);
      if (a >= b)
         return a - b;
      return a + (P64 - b);
   endfunction

   // full product, then fold; operands already reduced
   function automatic logic [63:0] mul_mod(input logic [63:0] a, input logic [63:0] b);
      return fold_mod({64'd0, a} * {64'd0, b});
   endfunction

   // square and multiply over all 64 exponent bits, msb first
   function automatic logic [63:0] pow_mod(input logic [63:0] base, input logic [63:0] e);
      logic [63:0] acc;
      acc = 64'd1;
      for (int i = 63; i >= 0; i--) begin
         acc = mul_mod(acc, acc);
         if (e[i])
            acc = mul_mod(acc, base);
      end
      return acc;
   endfunction

   // expected response of one request
   function automatic field_rsp_type compute_field_op(input logic [FUNC_W-1:0] func,
                                                      input logic [63:0] a_raw,
                                                      input logic [63:0] b_raw);
      logic [63:0]   a;
      logic [63:0]   b;
      logic [63:0]   res;
      logic          dz;
      field_rsp_type r;
      a   = fold_mod({64'd0, a_raw});
      b   = fold_mod({64'd0, b_raw});
      res = '0;
      dz  = 1'b0;
      case (func)
         FUNC_REDUCE: res = a;
         FUNC_ADD:    res = add_mod(a, b);
         FUNC_SUB:    res = sub_mod(a, b);
         FUNC_MUL:    res = mul_mod(a, b);
         FUNC_DIV: begin
            // divisor congruent to zero: zero result and the flag
            if (b == '0)
               dz = 1'b1;
            else
               res = mul_mod(a, pow_mod(b, P64 - 64'd2));
         end
         // exponent is used raw, not reduced
         FUNC_POW:    res = pow_mod(a, b_raw);
         default:     res = '0;
      endcase
      r.tdata = {3'b000, res[60:0]};
      r.tuser = dz;
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic void queue_request(input logic [FUNC_W-1:0] func, input logic [63:0] a,
                                         input logic [63:0] b, input logic hold = 1'b0);
      field_req_type item;
      item.func = func;
      item.a = a;
      item.b = b;
      item.hold_until_idle = hold;
      request_queue.push_back(item);
   endfunction

   // operand mix: full words, small values, around p, near the top, multiples of p, masked words
   function automatic logic [63:0] pick_operand();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(0, 6))
         0: return w;
         1: return 64'($urandom_range(0, 15));
         2: return P64 - 64'($urandom_range(0, 3));
         3: return P64 + 64'($urandom_range(0, 3));
         4: return ALL_ONES - 64'($urandom_range(0, 7));
         5: return P64 * 64'($urandom_range(0, 8));
         default: return w & P64;
      endcase
   endfunction

   // random bit length keeps most exponentiations short
   function automatic logic [63:0] pick_exponent();
      logic [63:0] e;
      e = {$urandom, $urandom};
      return e >> $urandom_range(0, 64);
   endfunction

   function automatic logic [FUNC_W-1:0] pick_func();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) return FUNC_REDUCE;
      if (r < 40) return FUNC_ADD;
      if (r < 60) return FUNC_SUB;
      if (r < 80) return FUNC_MUL;
      if (r < 86) return FUNC_DIV;
      if (r < 97) return FUNC_POW;
      return ($urandom_range(0, 1) != 0) ? FUNC_UNDEF_HI : FUNC_UNDEF_LO;
   endfunction

   // idle share per phase: sender busy-ish first, receiver busy-ish next, then none
   function automatic int send_idle_pct(input int done);
      int ph;
      ph = (total_items == 0) ? 0 : (done * 3) / total_items;
      case (ph)
         0:       return 29;
         1:       return 67;
         default: return 0;
      endcase
   endfunction

   function automatic int recv_idle_pct(input int done);
      int ph;
      ph = (total_items == 0) ? 0 : (done * 3) / total_items;
      case (ph)
         0:       return 67;
         1:       return 29;
         default: return 0;
      endcase
   endfunction

   // ---------------------------------------------------------------- driver

   // presents the head of the request queue; a held-off item waits until
   // nothing is in flight
   always @(posedge clock) begin
      field_req_type head;
      int            in_flight;
      logic          xfer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         xfer = req_tvalid && req_tready;
         if (xfer) begin
            void'(request_queue.pop_front());
            sent_count <= sent_count + 1;
         end
         if (req_tvalid && !req_tready) begin
            // stalled transfer: keep everything as is
         end else if (request_queue.size() == 0) begin
            req_tvalid <= 1'b0;
         end else begin
            head = request_queue[0];
            // recv_count may still hold its old value, which only lengthens a hold-off
            in_flight = sent_count - recv_count + (xfer ? 1 : 0);
            if ($urandom_range(0, 99) >= send_idle_pct(sent_count) &&
                (!head.hold_until_idle || in_flight == 0)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= {head.b, head.a};
               req_tuser  <= head.func;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   // predicts on each request transfer, checks each response transfer in order
   always @(posedge clock) begin
      field_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            results_due.push_back(compute_field_op(req_tuser, req_tdata[63:0],
                                                   req_tdata[127:64]));
         if (rsp_tvalid && rsp_tready) begin
            recv_count <= recv_count + 1;
            if (results_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response, expected none, actual tdata %h tuser %b",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               want = results_due.pop_front();
               if (rsp_tdata !== want.tdata) begin
                  mismatches++;
                  $display("%0t: field_result mismatch, expected %h, actual %h",
                           $time, want.tdata, rsp_tdata);
               end
               if (rsp_tuser !== want.tuser) begin
                  mismatches++;
                  $display("%0t: div_zero mismatch, expected %b, actual %b",
                           $time, want.tuser, rsp_tuser);
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct(sent_count));
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      // directed: operand extremes around p and the top of the word
      queue_request(FUNC_REDUCE, 64'd0, ALL_ONES);
      queue_request(FUNC_REDUCE, P64, 64'd0);
      queue_request(FUNC_REDUCE, P64 + 64'd1, 64'd0);
      queue_request(FUNC_REDUCE, ALL_ONES, ALL_ONES);
      queue_request(FUNC_REDUCE, P64 * 64'd2 + 64'd5, 64'd3);
      queue_request(FUNC_ADD, P64 - 64'd1, P64 - 64'd1);
      queue_request(FUNC_ADD, ALL_ONES, ALL_ONES);
      queue_request(FUNC_ADD, 64'd0, P64);
      queue_request(FUNC_SUB, 64'd0, 64'd1);
      queue_request(FUNC_SUB, 64'd5, P64 - 64'd1);
      queue_request(FUNC_SUB, ALL_ONES, 64'd0);
      queue_request(FUNC_MUL, P64 - 64'd1, P64 - 64'd1);
      queue_request(FUNC_MUL, ALL_ONES, ALL_ONES);
      queue_request(FUNC_MUL, 64'd0, ALL_ONES);
      // divide by zero in all its forms: zero, p, and the largest multiple of p
      queue_request(FUNC_DIV, 64'd7, 64'd0, 1'b1);
      queue_request(FUNC_DIV, 64'd7, P64);
      queue_request(FUNC_DIV, ALL_ONES, P64 * 64'd8);
      queue_request(FUNC_DIV, P64 - 64'd1, P64 - 64'd1);
      queue_request(FUNC_DIV, 64'd1, 64'd2);
      // zero to the zeroth power, and any base with a zero exponent
      queue_request(FUNC_POW, 64'd0, 64'd0);
      queue_request(FUNC_POW, 64'd123, 64'd0);
      queue_request(FUNC_POW, P64 - 64'd1, ALL_ONES);
      queue_request(FUNC_POW, 64'd3, P64 - 64'd2);
      // undefined codes still answer with zero
      queue_request(FUNC_UNDEF_LO, ALL_ONES, ALL_ONES);
      queue_request(FUNC_UNDEF_HI, 64'd5, 64'd0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         logic [FUNC_W-1:0] f;
         f = pick_func();
         queue_request(f, pick_operand(), (f == FUNC_POW) ? pick_exponent() : pick_operand(),
                       (i % 150) == 149);
      end
      total_items = request_queue.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // every request taken, every response back, then a quiet stretch
      while (sent_count < total_items || recv_count < total_items)
         @(posedge clock);
      repeat (END_QUIET_CYCLES) @(posedge clock);

      if (results_due.size() != 0) begin
         mismatches++;
         $display("%0t: responses missing, expected %0d more, actual 0",
                  $time, results_due.size());
      end
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
